// ===== hdl/best_fit_coalescing_allocator_macros.svh =====
// Assertion macros for the best-fit allocator.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef BEST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define BEST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BFCA_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("allocator assertion failed");
`define BFCA_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("allocator assertion failed");
`else
`define BFCA_ASSERT_IMPL(label, a, c)
`define BFCA_ASSERT_NEXT(label, a, c)
`endif
`endif

// ===== hdl/bfca_pkg.sv =====
// Shared types and constants of the best-fit allocator.
// Used by bfca_cell and best_fit_coalescing_allocator; depends on nothing.
package bfca_pkg;

  localparam int GW            = 13;
  localparam int ARENA         = 8192;
  localparam int GRANULE_BYTES = 8;
  localparam int GB_SHIFT      = 3;
  localparam int SLOT_W        = 10;
  localparam int HEAD_W        = GW + 3;
  localparam int H_ALLOC       = GW;
  localparam int H_FREE        = GW + 1;
  localparam int H_PREV        = GW + 2;

  typedef logic [GW-1:0]     gran_t;
  typedef logic [GW:0]       gran_ext_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam gran_t USABLE = gran_t'(ARENA - 1);

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_IGNORED = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [16:0] granted_bytes;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic  en;
    slot_t idx;
    logic  valid;
    gran_t start;
    gran_t size;
  } span_wr_t;

  // Search token that walks the row of span cells.
  typedef struct packed {
    logic      live;
    gran_ext_t szg;
    logic      nkey_en;
    gran_t     nkey;
    logic      pkey_en;
    gran_t     pkey;
    logic      fit_ok;
    slot_t     fit_idx;
    gran_t     fit_size;
    gran_t     fit_start;
    logic      n_ok;
    slot_t     n_idx;
    gran_t     n_size;
    logic      p_ok;
    slot_t     p_idx;
    logic      free_ok;
    slot_t     free_idx;
  } token_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_HEAD,
    ST_RD_NEXT,
    ST_PREV_CHK,
    ST_RD_FOOT,
    ST_RD_PREV,
    ST_LAUNCH,
    ST_SEARCH,
    ST_DECIDE,
    ST_A_WR,
    ST_A_HEAD,
    ST_R_NEXT_WR,
    ST_R_PREV_WR,
    ST_R_MERGE,
    ST_FIX,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/bfca_cell.sv =====
// One entry of the free span table, with its stage of the search token row.
// Depends on bfca_pkg.
module bfca_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bfca_pkg::span_wr_t wr,
  input  bfca_pkg::token_t  tok_i,
  output bfca_pkg::token_t  tok_o
);

  logic              valid_r;
  bfca_pkg::gran_t   start_r;
  bfca_pkg::gran_t   size_r;
  bfca_pkg::token_t  tok_r;
  bfca_pkg::token_t  tok_nxt;
  bfca_pkg::slot_t   my_idx;
  logic              fits;
  logic              better;

  assign my_idx = bfca_pkg::slot_t'(IDX);

  always_comb begin
    tok_nxt = tok_i;
    fits    = valid_r && ({1'b0, size_r} >= tok_i.szg);
    better  = !tok_i.fit_ok || (size_r < tok_i.fit_size) ||
              ((size_r == tok_i.fit_size) && (start_r < tok_i.fit_start));
    // The smallest fitting span wins; a tie in size goes to the lower start address, not to the earlier cell.
    if (fits && better) begin
      tok_nxt.fit_ok    = 1'b1;
      tok_nxt.fit_idx   = my_idx;
      tok_nxt.fit_size  = size_r;
      tok_nxt.fit_start = start_r;
    end
    if (!tok_i.n_ok && tok_i.nkey_en && valid_r && start_r == tok_i.nkey) begin
      tok_nxt.n_ok   = 1'b1;
      tok_nxt.n_idx  = my_idx;
      tok_nxt.n_size = size_r;
    end
    if (!tok_i.p_ok && tok_i.pkey_en && valid_r && start_r == tok_i.pkey) begin
      tok_nxt.p_ok  = 1'b1;
      tok_nxt.p_idx = my_idx;
    end
    if (!tok_i.free_ok && !valid_r) begin
      tok_nxt.free_ok  = 1'b1;
      tok_nxt.free_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= (IDX == 0);
      start_r <= '0;
      size_r  <= (IDX == 0) ? bfca_pkg::USABLE : '0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr.en && wr.idx == my_idx) begin
        valid_r <= wr.valid;
        start_r <= wr.start;
        size_r  <= wr.size;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== hdl/best_fit_coalescing_allocator.sv =====
// Best-fit heap allocator with boundary tags over an arena of 8-byte granules.
// After reset the block clears its tag memory and takes no transfer while it
// does so; configuration writes are taken as ever. An allocate then goes
// straight to the search, and a release first reads its own head tag and the
// tags of its neighbours: the free span table is a row of MAX_FREE_SPANS
// cells and a search token walks it one cell a cycle, and the tag memory
// reads and writes the neighbours in successive states. A release refused at
// once (null, misaligned or out-of-range address) does none of this, and a
// release of an address that heads no allocated span stops after its head
// read. A result waits in place while the output is stalled.
// Depends on bfca_pkg, bfca_cell and the assertion macro header.
`include "best_fit_coalescing_allocator_macros.svh"
module best_fit_coalescing_allocator #(
  parameter int MAX_FREE_SPANS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfca_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bfca_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [9:0]          cfg_wdata
);

  localparam int GW = bfca_pkg::GW;

  bfca_pkg::state_t    state_r, state_nxt;
  bfca_pkg::gran_t     clr_cnt_r, clr_cnt_nxt;
  bfca_pkg::in_item_t  item_r, item_nxt;
  bfca_pkg::gran_ext_t szg_r, szg_nxt;
  bfca_pkg::gran_t     hg_r, hg_nxt;
  bfca_pkg::gran_t     sz_r, sz_nxt;
  bfca_pkg::gran_t     n_r, n_nxt;
  bfca_pkg::gran_t     ps_r, ps_nxt;
  bfca_pkg::gran_t     pstart_r, pstart_nxt;
  logic                nfree_r, nfree_nxt;
  logic                pfree_r, pfree_nxt;
  logic                prevflag_r, prevflag_nxt;
  bfca_pkg::token_t    rtok_r, rtok_nxt;
  bfca_pkg::gran_t     mstart_r, mstart_nxt;
  bfca_pkg::gran_t     msize_r, msize_nxt;
  bfca_pkg::slot_t     mslot_r, mslot_nxt;
  bfca_pkg::gran_t     fix_addr_r, fix_addr_nxt;
  logic                fix_set_r, fix_set_nxt;
  bfca_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  bfca_pkg::out_item_t out_data_r, out_data_nxt;
  logic [9:0]          min_span_r;

  logic [bfca_pkg::HEAD_W-1:0] head_mem [bfca_pkg::ARENA];
  bfca_pkg::gran_t             foot_mem [bfca_pkg::ARENA];
  logic                        head_we, head_re, foot_we, foot_re;
  bfca_pkg::gran_t             head_wa, head_ra, foot_wa, foot_ra;
  logic [bfca_pkg::HEAD_W-1:0] head_wd, head_q_r;
  bfca_pkg::gran_t             foot_wd, foot_q_r;

  bfca_pkg::span_wr_t span_wr;
  bfca_pkg::token_t   inject_tok;
  bfca_pkg::token_t   tok_w [MAX_FREE_SPANS+1];

  // Combinational helpers.
  logic [16:0]         need, mb17, need_m;
  logic [15:0]         addr_g;
  logic [GW+1:0]       n_ext;
  bfca_pkg::gran_t     rem;
  logic [GW+2:0]       rem_bytes;
  logic [GW+1:0]       end_ext;
  logic [GW+1:0]       msum;
  logic                bad_addr;

  assign in_ready  = (state_r == bfca_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tok_w[0] = inject_tok;

  for (genvar i = 0; i < MAX_FREE_SPANS; i++) begin : g_cell
    bfca_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .wr    (span_wr),
      .tok_i (tok_w[i]),
      .tok_o (tok_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_q_r <= head_mem[head_ra];
    if (foot_we) foot_mem[foot_wa] <= foot_wd;
    if (foot_re) foot_q_r <= foot_mem[foot_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    item_nxt      = item_r;
    szg_nxt       = szg_r;
    hg_nxt        = hg_r;
    sz_nxt        = sz_r;
    n_nxt         = n_r;
    ps_nxt        = ps_r;
    pstart_nxt    = pstart_r;
    nfree_nxt     = nfree_r;
    pfree_nxt     = pfree_r;
    prevflag_nxt  = prevflag_r;
    rtok_nxt      = rtok_r;
    mstart_nxt    = mstart_r;
    msize_nxt     = msize_r;
    mslot_nxt     = mslot_r;
    fix_addr_nxt  = fix_addr_r;
    fix_set_nxt   = fix_set_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    head_we = 1'b0; head_wa = '0; head_wd = '0;
    head_re = 1'b0; head_ra = '0;
    foot_we = 1'b0; foot_wa = '0; foot_wd = '0;
    foot_re = 1'b0; foot_ra = '0;
    span_wr    = '0;
    inject_tok = '0;

    mb17   = (min_span_r < 10'(bfca_pkg::GRANULE_BYTES)) ?
             17'(bfca_pkg::GRANULE_BYTES) : {7'd0, min_span_r};
    need   = {1'b0, in_data.request_bytes} + 17'(bfca_pkg::GRANULE_BYTES);
    need_m = (need < mb17) ? mb17 : need;
    addr_g = in_data.release_address >> bfca_pkg::GB_SHIFT;
    bad_addr = (in_data.release_address == 16'd0) ||
               (in_data.release_address[bfca_pkg::GB_SHIFT-1:0] != '0) ||
               ({1'b0, addr_g} - 17'd1 >= 17'(bfca_pkg::USABLE));
    n_ext     = {2'b00, hg_r} + {2'b00, head_q_r[GW-1:0]};
    rem       = rtok_r.fit_size - rtok_r.szg[GW-1:0];
    rem_bytes = {rem, 3'b000};
    end_ext   = {2'b00, mstart_r} + {2'b00, msize_r};
    msum      = {2'b00, sz_r} + (rtok_r.n_ok ? {2'b00, rtok_r.n_size} : '0) +
                (rtok_r.p_ok ? {2'b00, ps_r} : '0);

    unique case (state_r)
      bfca_pkg::ST_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_cnt_r;
        head_wd = (clr_cnt_r == '0) ?
                  {3'b010, bfca_pkg::USABLE} : '0;
        foot_we = (clr_cnt_r == '0);
        foot_wa = bfca_pkg::USABLE - 1'b1;
        foot_wd = bfca_pkg::USABLE;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) state_nxt = bfca_pkg::ST_IDLE;
      end
      bfca_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.kind == bfca_pkg::KIND_ALLOC) begin
            szg_nxt   = bfca_pkg::gran_ext_t'((need_m + 17'd7) >> bfca_pkg::GB_SHIFT);
            state_nxt = bfca_pkg::ST_LAUNCH;
          end else if (bad_addr) begin
            res_nxt   = '{16'd0, 17'd0, bfca_pkg::STATUS_IGNORED};
            state_nxt = bfca_pkg::ST_FINISH;
          end else begin
            hg_nxt    = bfca_pkg::gran_t'(addr_g - 16'd1);
            head_re   = 1'b1;
            head_ra   = bfca_pkg::gran_t'(addr_g - 16'd1);
            state_nxt = bfca_pkg::ST_RD_HEAD;
          end
        end
      end
      bfca_pkg::ST_RD_HEAD: begin
        if (!head_q_r[bfca_pkg::H_ALLOC]) begin
          res_nxt   = '{16'd0, 17'd0, bfca_pkg::STATUS_IGNORED};
          state_nxt = bfca_pkg::ST_FINISH;
        end else begin
          sz_nxt       = head_q_r[GW-1:0];
          prevflag_nxt = head_q_r[bfca_pkg::H_PREV];
          n_nxt        = n_ext[GW-1:0];
          nfree_nxt    = 1'b0;
          if (n_ext < {2'b00, bfca_pkg::USABLE}) begin
            head_re   = 1'b1;
            head_ra   = n_ext[GW-1:0];
            state_nxt = bfca_pkg::ST_RD_NEXT;
          end else begin
            state_nxt = bfca_pkg::ST_PREV_CHK;
          end
        end
      end
      bfca_pkg::ST_RD_NEXT: begin
        nfree_nxt = head_q_r[bfca_pkg::H_FREE];
        state_nxt = bfca_pkg::ST_PREV_CHK;
      end
      bfca_pkg::ST_PREV_CHK: begin
        pfree_nxt = 1'b0;
        if (prevflag_r && hg_r != '0) begin
          foot_re   = 1'b1;
          foot_ra   = hg_r - 1'b1;
          state_nxt = bfca_pkg::ST_RD_FOOT;
        end else begin
          state_nxt = bfca_pkg::ST_LAUNCH;
        end
      end
      bfca_pkg::ST_RD_FOOT: begin
        ps_nxt = foot_q_r;
        if (foot_q_r != '0 && foot_q_r <= hg_r) begin
          pstart_nxt = hg_r - foot_q_r;
          head_re    = 1'b1;
          head_ra    = hg_r - foot_q_r;
          state_nxt  = bfca_pkg::ST_RD_PREV;
        end else begin
          state_nxt = bfca_pkg::ST_LAUNCH;
        end
      end
      bfca_pkg::ST_RD_PREV: begin
        pfree_nxt = head_q_r[bfca_pkg::H_FREE];
        state_nxt = bfca_pkg::ST_LAUNCH;
      end
      bfca_pkg::ST_LAUNCH: begin
        inject_tok.live    = 1'b1;
        inject_tok.szg     = szg_r;
        inject_tok.nkey_en = (item_r.kind == bfca_pkg::KIND_RELEASE) && nfree_r;
        inject_tok.nkey    = n_r;
        inject_tok.pkey_en = (item_r.kind == bfca_pkg::KIND_RELEASE) && pfree_r;
        inject_tok.pkey    = pstart_r;
        state_nxt = bfca_pkg::ST_SEARCH;
      end
      bfca_pkg::ST_SEARCH: begin
        if (tok_w[MAX_FREE_SPANS].live) begin
          rtok_nxt  = tok_w[MAX_FREE_SPANS];
          state_nxt = bfca_pkg::ST_DECIDE;
        end
      end
      bfca_pkg::ST_DECIDE: begin
        if (item_r.kind == bfca_pkg::KIND_ALLOC) begin
          if (!rtok_r.fit_ok) begin
            res_nxt   = '{16'd0, 17'd0, bfca_pkg::STATUS_NO_FIT};
            state_nxt = bfca_pkg::ST_FINISH;
          end else begin
            state_nxt = bfca_pkg::ST_A_WR;
          end
        end else if (!rtok_r.n_ok && !rtok_r.p_ok && !rtok_r.free_ok) begin
          res_nxt   = '{16'd0, 17'd0, bfca_pkg::STATUS_FULL};
          state_nxt = bfca_pkg::ST_FINISH;
        end else begin
          msize_nxt  = msum[GW-1:0];
          mstart_nxt = rtok_r.p_ok ? pstart_r : hg_r;
          mslot_nxt  = rtok_r.p_ok ? rtok_r.p_idx :
                       (rtok_r.n_ok ? rtok_r.n_idx : rtok_r.free_idx);
          res_nxt    = '{16'd0, 17'({msum[GW-1:0], 3'b000}), bfca_pkg::STATUS_OK};
          state_nxt  = bfca_pkg::ST_R_NEXT_WR;
        end
      end
      bfca_pkg::ST_A_WR: begin
        span_wr.en  = 1'b1;
        span_wr.idx = rtok_r.fit_idx;
        if ({1'b0, rem_bytes} >= mb17) begin
          // Split: the tail stays free under the same table entry.
          span_wr.valid = 1'b1;
          span_wr.start = rtok_r.fit_start + rtok_r.szg[GW-1:0];
          span_wr.size  = rem;
          head_we = 1'b1;
          head_wa = rtok_r.fit_start + rtok_r.szg[GW-1:0];
          head_wd = {3'b010, rem};
          foot_we = 1'b1;
          foot_wa = rtok_r.fit_start + rtok_r.szg[GW-1:0] + rem - 1'b1;
          foot_wd = rem;
          res_nxt = '{16'({rtok_r.fit_start, 3'b000}) + 16'(bfca_pkg::GRANULE_BYTES),
                      17'({rtok_r.szg[GW-1:0], 3'b000}), bfca_pkg::STATUS_OK};
          state_nxt = bfca_pkg::ST_A_HEAD;
        end else begin
          span_wr.valid = 1'b0;
          span_wr.start = rtok_r.fit_start;
          span_wr.size  = rtok_r.fit_size;
          head_we = 1'b1;
          head_wa = rtok_r.fit_start;
          head_wd = {3'b001, rtok_r.fit_size};
          res_nxt = '{16'({rtok_r.fit_start, 3'b000}) + 16'(bfca_pkg::GRANULE_BYTES),
                      17'({rtok_r.fit_size, 3'b000}), bfca_pkg::STATUS_OK};
          if ({1'b0, rtok_r.fit_start} + {1'b0, rtok_r.fit_size} <
              {1'b0, bfca_pkg::USABLE}) begin
            head_re      = 1'b1;
            head_ra      = rtok_r.fit_start + rtok_r.fit_size;
            fix_addr_nxt = rtok_r.fit_start + rtok_r.fit_size;
            fix_set_nxt  = 1'b0;
            state_nxt    = bfca_pkg::ST_FIX;
          end else begin
            state_nxt = bfca_pkg::ST_FINISH;
          end
        end
      end
      bfca_pkg::ST_A_HEAD: begin
        head_we   = 1'b1;
        head_wa   = rtok_r.fit_start;
        head_wd   = {3'b001, rtok_r.szg[GW-1:0]};
        state_nxt = bfca_pkg::ST_FINISH;
      end
      bfca_pkg::ST_R_NEXT_WR: begin
        if (rtok_r.n_ok) begin
          span_wr.en    = 1'b1;
          span_wr.idx   = rtok_r.n_idx;
          span_wr.valid = 1'b0;
          head_we = 1'b1;
          head_wa = n_r;
          head_wd = '0;
        end
        state_nxt = bfca_pkg::ST_R_PREV_WR;
      end
      bfca_pkg::ST_R_PREV_WR: begin
        if (rtok_r.p_ok) begin
          head_we = 1'b1;
          head_wa = hg_r;
          head_wd = '0;
        end
        state_nxt = bfca_pkg::ST_R_MERGE;
      end
      bfca_pkg::ST_R_MERGE: begin
        span_wr = '{1'b1, mslot_r, 1'b1, mstart_r, msize_r};
        head_we = 1'b1;
        head_wa = mstart_r;
        head_wd = {3'b010, msize_r};
        foot_we = 1'b1;
        foot_wa = mstart_r + msize_r - 1'b1;
        foot_wd = msize_r;
        if (end_ext < {2'b00, bfca_pkg::USABLE}) begin
          head_re      = 1'b1;
          head_ra      = end_ext[GW-1:0];
          fix_addr_nxt = end_ext[GW-1:0];
          fix_set_nxt  = 1'b1;
          state_nxt    = bfca_pkg::ST_FIX;
        end else begin
          state_nxt = bfca_pkg::ST_FINISH;
        end
      end
      bfca_pkg::ST_FIX: begin
        // Read-modify-write of the previous-span-free flag of the next span.
        head_we = 1'b1;
        head_wa = fix_addr_r;
        head_wd = head_q_r;
        head_wd[bfca_pkg::H_PREV] = fix_set_r;
        state_nxt = bfca_pkg::ST_FINISH;
      end
      bfca_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = bfca_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfca_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      min_span_r  <= 10'd48;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) min_span_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    szg_r      <= szg_nxt;
    hg_r       <= hg_nxt;
    sz_r       <= sz_nxt;
    n_r        <= n_nxt;
    ps_r       <= ps_nxt;
    pstart_r   <= pstart_nxt;
    nfree_r    <= nfree_nxt;
    pfree_r    <= pfree_nxt;
    prevflag_r <= prevflag_nxt;
    rtok_r     <= rtok_nxt;
    mstart_r   <= mstart_nxt;
    msize_r    <= msize_nxt;
    mslot_r    <= mslot_nxt;
    fix_addr_r <= fix_addr_nxt;
    fix_set_r  <= fix_set_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `BFCA_ASSERT_IMPL(a_token_only_in_search, tok_w[MAX_FREE_SPANS].live, state_r == bfca_pkg::ST_SEARCH)
  `BFCA_ASSERT_NEXT(a_clear_exits_to_idle, state_r == bfca_pkg::ST_CLEAR, state_r == bfca_pkg::ST_CLEAR || state_r == bfca_pkg::ST_IDLE)
  `BFCA_ASSERT_IMPL(a_grant_aligned, state_r == bfca_pkg::ST_FINISH && res_r.status == bfca_pkg::STATUS_OK && item_r.kind == bfca_pkg::KIND_ALLOC, res_r.payload_address[2:0] == 3'd0 && res_r.granted_bytes != 17'd0)
  `BFCA_ASSERT_IMPL(a_fail_grants_nothing, state_r == bfca_pkg::ST_FINISH && res_r.status != bfca_pkg::STATUS_OK, res_r.payload_address == 16'd0 && res_r.granted_bytes == 17'd0)

endmodule

// ===== tb/sv/best_fit_coalescing_allocator_tb.sv =====
// Self-checking testbench for the best-fit coalescing allocator.
// Predicts every result from its own span table and tag store; needs bfca_pkg and the top level.
module best_fit_coalescing_allocator_tb;

  localparam int NSPANS = 64;
  localparam int NGRAN  = 8192;
  localparam int USE_G  = NGRAN - 1;
  localparam int LIMIT  = 50000;
  localparam int GRAN_B = bfca_pkg::GRANULE_BYTES;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bfca_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bfca_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;

  best_fit_coalescing_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Allocator shadow state.
  logic        span_ok [NSPANS];
  int unsigned span_at [NSPANS];
  int unsigned span_sz [NSPANS];
  int unsigned head_sz [NGRAN];
  logic        head_al [NGRAN], head_fr [NGRAN], head_pv [NGRAN];
  int unsigned foot_sz [NGRAN];
  int unsigned min_span;

  bfca_pkg::in_item_t  pending_reqs[$];
  bfca_pkg::out_item_t expected_results[$];
  int unsigned live_addrs[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void shadow_reset();
    for (int i = 0; i < NSPANS; i++) begin
      span_ok[i] = 0; span_at[i] = 0; span_sz[i] = 0;
    end
    for (int g = 0; g < NGRAN; g++) begin
      head_sz[g] = 0; head_al[g] = 0; head_fr[g] = 0; head_pv[g] = 0; foot_sz[g] = 0;
    end
    span_ok[0] = 1; span_sz[0] = USE_G;
    head_sz[0] = USE_G; head_fr[0] = 1;
    foot_sz[USE_G-1] = USE_G;
    min_span = 48;
  endfunction

  function automatic int find_span(int unsigned st);
    for (int i = 0; i < NSPANS; i++)
      if (span_ok[i] && span_at[i] == st) return i;
    return -1;
  endfunction

  function automatic bfca_pkg::out_item_t predict_alloc(int unsigned req);
    bfca_pkg::out_item_t r;
    int unsigned mb, need, szg, s, sz, rem, tail;
    int best;
    r = '0;
    best = -1;
    mb = (min_span < GRAN_B) ? GRAN_B : min_span;
    need = req + GRAN_B;
    if (need < mb) need = mb;
    szg = (need + GRAN_B - 1) / GRAN_B;
    for (int i = 0; i < NSPANS; i++) begin
      if (!span_ok[i] || span_sz[i] < szg) continue;
      if (best < 0 || span_sz[i] < span_sz[best] ||
          (span_sz[i] == span_sz[best] && span_at[i] < span_at[best])) best = i;
    end
    if (best < 0) begin
      r.status = bfca_pkg::STATUS_NO_FIT;
      return r;
    end
    s = span_at[best]; sz = span_sz[best]; rem = sz - szg;
    if (rem * GRAN_B >= mb) begin
      tail = s + szg;
      span_at[best] = tail; span_sz[best] = rem;
      head_sz[tail] = rem; head_fr[tail] = 1; head_al[tail] = 0; head_pv[tail] = 0;
      foot_sz[tail+rem-1] = rem;
    end else begin
      szg = sz;
      span_ok[best] = 0;
      if (s + sz < USE_G) head_pv[s+sz] = 0;
    end
    head_sz[s] = szg; head_al[s] = 1; head_fr[s] = 0; head_pv[s] = 0;
    r.payload_address = 16'((s + 1) * GRAN_B);
    r.granted_bytes = 17'(szg * GRAN_B);
    r.status = bfca_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic bfca_pkg::out_item_t predict_release(int unsigned addr);
    bfca_pkg::out_item_t r;
    int unsigned hg, sz, nx, st, size, ps, pst;
    int nslot, pslot, slot;
    r = '0;
    nslot = -1; pslot = -1; slot = -1; ps = 0; pst = 0;
    if (addr == 0 || addr % GRAN_B != 0 || addr / GRAN_B - 1 >= USE_G) begin
      r.status = bfca_pkg::STATUS_IGNORED;
      return r;
    end
    hg = addr / GRAN_B - 1;
    if (!head_al[hg]) begin
      r.status = bfca_pkg::STATUS_IGNORED;
      return r;
    end
    sz = head_sz[hg];
    nx = hg + sz;
    if (nx < USE_G && head_fr[nx]) nslot = find_span(nx);
    if (head_pv[hg] && hg > 0) begin
      ps = foot_sz[hg-1];
      if (ps > 0 && ps <= hg) begin
        pst = hg - ps;
        if (head_fr[pst]) pslot = find_span(pst);
      end
    end
    if (pslot < 0 && nslot < 0) begin
      for (int i = 0; i < NSPANS; i++)
        if (!span_ok[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) begin
        r.status = bfca_pkg::STATUS_FULL;
        return r;
      end
    end
    st = hg; size = sz;
    if (nslot >= 0) begin
      size += span_sz[nslot];
      head_sz[nx] = 0; head_al[nx] = 0; head_fr[nx] = 0; head_pv[nx] = 0;
      span_ok[nslot] = 0;
      slot = nslot;
    end
    if (pslot >= 0) begin
      head_sz[hg] = 0; head_al[hg] = 0; head_fr[hg] = 0; head_pv[hg] = 0;
      st = pst; size += ps; slot = pslot;
    end
    span_ok[slot] = 1; span_at[slot] = st; span_sz[slot] = size;
    // The merged head is written afresh and carries no previous-span-free flag.
    head_sz[st] = size; head_fr[st] = 1; head_al[st] = 0; head_pv[st] = 0;
    foot_sz[st+size-1] = size;
    if (st + size < USE_G) head_pv[st+size] = 1;
    r.granted_bytes = 17'(size * GRAN_B);
    r.status = bfca_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic void queue_alloc(int unsigned bytes);
    bfca_pkg::in_item_t it;
    it.kind = bfca_pkg::KIND_ALLOC;
    it.request_bytes = 16'(bytes);
    it.release_address = 16'($urandom);
    pending_reqs.push_back(it);
  endfunction

  function automatic void queue_release(int unsigned addr);
    bfca_pkg::in_item_t it;
    it.kind = bfca_pkg::KIND_RELEASE;
    it.request_bytes = 16'($urandom);
    it.release_address = 16'(addr);
    pending_reqs.push_back(it);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Driver: presents queued items, keeping valid and payload steady until the transfer.
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (pending_reqs.size() > 0 && gap_len() == 0) begin
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_gap <= gap_len();
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Prediction happens at the input transfer, in order.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (in_data.kind == bfca_pkg::KIND_ALLOC) begin
        bfca_pkg::out_item_t r;
        r = predict_alloc(in_data.request_bytes);
        if (r.status == bfca_pkg::STATUS_OK) live_addrs.push_back(r.payload_address);
        expected_results.push_back(r);
      end else begin
        bfca_pkg::out_item_t r;
        r = predict_release(in_data.release_address);
        if (r.status == bfca_pkg::STATUS_OK)
          foreach (live_addrs[i])
            if (live_addrs[i] == in_data.release_address) begin
              live_addrs.delete(i);
              break;
            end
        expected_results.push_back(r);
      end
    end
  end

  // Monitor and receiver-side stalls.
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          bfca_pkg::out_item_t w;
          w = expected_results.pop_front();
          if (out_data.payload_address !== w.payload_address)
            report("payload_address", out_data.payload_address, w.payload_address);
          if (out_data.granted_bytes !== w.granted_bytes)
            report("granted_bytes", out_data.granted_bytes, w.granted_bytes);
          if (out_data.status !== w.status)
            report("status", out_data.status, w.status);
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (out_ready && $urandom_range(0, 3) == 0) begin
        out_gap <= gap_len();
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // Watchdog over cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_min_span(int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 10'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    min_span = v;
  endtask

  function automatic void random_phase(int n);
    int unsigned p, a;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        if ($urandom_range(0, 9) == 0) queue_alloc($urandom);
        else queue_alloc($urandom_range(0, 600));
      end else if (p < 85) begin
        // Release a random granule-aligned address, which is mostly not live.
        a = $urandom_range(1, 400) * GRAN_B;
        queue_release(a);
      end else if (p < 92) queue_release($urandom);
      else queue_release(0);
    end
  endfunction

  int unsigned cfg_vals[6] = '{16, 512, 8, 0, 1023, 40};

  initial begin
    shadow_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_min_span(48);

    // Directed items: extremes, exact fits, bad releases and merges.
    queue_alloc(0);
    queue_alloc(16'hFFFF);
    queue_alloc(40);
    queue_alloc(100);
    queue_alloc(1);
    queue_release(16);
    queue_release(16);
    queue_release(0);
    queue_release(13);
    queue_release(16'hFFF8);
    queue_release(16'hFFFF);
    queue_alloc(20000);
    queue_alloc(45000);
    queue_release(64);
    queue_release(72);
    queue_alloc(0);
    queue_alloc(8);
    queue_release(8);
    drain();

    foreach (cfg_vals[c]) begin
      set_min_span(cfg_vals[c]);
      if (c == 1) begin
        // Allocate a run of small spans, then release a spread of addresses, of which few are live.
        for (int k = 0; k < 80; k++) queue_alloc(8);
        drain();
        for (int k = 0; k < 80; k += 2) queue_release(8 + k * 528);
        drain();
      end
      // Releases of live addresses mixed with random allocations and releases.
      for (int k = 0; k < 330; k++) begin
        if (live_addrs.size() > 0 && $urandom_range(0, 1) == 0)
          queue_release(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
        else random_phase(1);
      end
      if (c == 2) begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bfca_pkg.sv
hdl/bfca_cell.sv
hdl/best_fit_coalescing_allocator.sv
tb/sv/best_fit_coalescing_allocator_tb.sv
